// ===== rtl/core/double_square_root_core_macros.svh =====
// Assertion macros for the double square root core.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef DOUBLE_SQUARE_ROOT_CORE_MACROS_SVH
`define DOUBLE_SQUARE_ROOT_CORE_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define DSR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and constants of the binary64 square root core.
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

	localparam int FRAC_W      = 52;
	localparam int EXP_W       = 11;
	localparam int MANT_W      = 54;
	localparam int ROOT_W      = 53;
	localparam int REM_W       = 56;
	localparam int ROOT_STEPS  = 53;
	localparam int LZ_W        = 6;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [63:0] INF_BITS  = 64'h7ff0_0000_0000_0000;
	localparam logic [63:0] QNAN_BITS = 64'h7ff8_0000_0000_0000;

	typedef enum logic [1:0] {
		KIND_NORM,
		KIND_QNAN,
		KIND_INF,
		KIND_ZERO
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                sgn;
		logic [EXP_W-1:0]    rexp;
		logic [MANT_W-1:0]   mant;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsr_front.sv =====
// ----------------------------------------------------------------------------
// dsr_front
// Two-stage front end: leading-zero count, then classify, normalize and
// halve the exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          operand_valid,
	output logic               operand_ready,
	input  wire logic [63:0]   operand_bits,
	input  wire logic          q_full,
	output logic               push,
	output dsr_pkg::item_t     push_item
);

	logic                      v_s1;
	logic [63:0]               x_s1;
	logic [dsr_pkg::LZ_W-1:0]  lz_s1;
	logic                      v_s2;
	dsr_pkg::item_t            item_s2;

	logic [dsr_pkg::LZ_W-1:0]  lz_c;
	logic                      found_c;
	dsr_pkg::item_t            item_c;
	logic                      f_adv;

	always_comb begin
		lz_c    = '0;
		found_c = 1'b0;
		for (int i = dsr_pkg::FRAC_W - 1; i >= 0; i--) begin
			if (!found_c && operand_bits[i]) begin
				found_c = 1'b1;
				lz_c    = dsr_pkg::LZ_W'(dsr_pkg::FRAC_W - 1 - i);
			end
		end
	end

	always_comb begin
		logic [dsr_pkg::EXP_W-1:0]  exf;
		logic signed [12:0]         e;
		logic [dsr_pkg::MANT_W-1:0] m;
		logic signed [12:0]         h;
		exf = x_s1[62:52];
		if (exf == '0) begin
			m = {2'b00, x_s1[dsr_pkg::FRAC_W-1:0]} << ({1'b0, lz_s1} + 7'd1);
			e = -13'sd1023 - 13'(signed'({1'b0, lz_s1}));
		end else begin
			m = {2'b01, x_s1[dsr_pkg::FRAC_W-1:0]};
			e = 13'(signed'({2'b00, exf})) - 13'sd1023;
		end
		if (e[0]) begin
			m = {m[dsr_pkg::MANT_W-2:0], 1'b0};
			e = e - 13'sd1;
		end
		h = (e >>> 1) + 13'sd1023;
		item_c.sgn  = x_s1[63];
		item_c.rexp = h[dsr_pkg::EXP_W-1:0];
		item_c.mant = m;
		priority if (x_s1[62:0] == '0) begin
			item_c.kind = dsr_pkg::KIND_ZERO;
		end else if (x_s1 == dsr_pkg::INF_BITS) begin
			item_c.kind = dsr_pkg::KIND_INF;
		end else if (x_s1[63] || exf == '1) begin
			item_c.kind = dsr_pkg::KIND_QNAN;
		end else begin
			item_c.kind = dsr_pkg::KIND_NORM;
		end
	end

	// hold both stages while stage two holds an item and the queue is full
	assign f_adv         = !v_s2 || !q_full;
	assign operand_ready = f_adv;
	assign push          = v_s2 && !q_full;
	assign push_item     = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (f_adv) begin
			v_s1 <= operand_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (f_adv) begin
			x_s1    <= operand_bits;
			lz_s1   <= lz_c;
			item_s2 <= item_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dsr_queue.sv =====
// ----------------------------------------------------------------------------
// dsr_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_queue #(
	parameter int DEPTH = dsr_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dsr_pkg::item_t  push_item,
	input  wire logic            pop,
	output dsr_pkg::item_t       head,
	output logic                 full,
	output logic                 empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dsr_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop)  rd_q <= nxt(rd_q);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ===== rtl/core/dsr_back.sv =====
// ----------------------------------------------------------------------------
// dsr_back
// Digit-recurrence root pipeline: one root bit per stage, then combinational
// rounding and packing after the last stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dsr_pkg::item_t  head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 root_valid,
	input  wire logic            root_ready,
	output logic [63:0]          root_bits
);

	localparam int N = dsr_pkg::ROOT_STEPS;

	logic                          v_s    [N+1];
	dsr_pkg::kind_t                kind_s [N+1];
	logic                          sgn_s  [N+1];
	logic [dsr_pkg::EXP_W-1:0]     rexp_s [N+1];
	logic [dsr_pkg::MANT_W-1:0]    mant_s [N+1];
	logic [dsr_pkg::ROOT_W-1:0]    q_s    [N+1];
	logic [dsr_pkg::REM_W-1:0]     rem_s  [N+1];

	logic [dsr_pkg::MANT_W-1:0]    mant_n [N];
	logic [dsr_pkg::ROOT_W-1:0]    q_n    [N];
	logic [dsr_pkg::REM_W-1:0]     rem_n  [N];
	logic                          adv;

	// the whole pipeline moves unless the finished item is stalled
	assign adv = !v_s[N] || root_ready;
	assign pop = adv && !empty;

	for (genvar k = 0; k < N; k++) begin : g_step
		always_comb begin
			logic [dsr_pkg::REM_W-1:0] r;
			logic [dsr_pkg::REM_W-1:0] t;
			r = {rem_s[k][dsr_pkg::REM_W-3:0], mant_s[k][dsr_pkg::MANT_W-1 -: 2]};
			t = {1'b0, q_s[k], 2'b01};
			mant_n[k] = {mant_s[k][dsr_pkg::MANT_W-3:0], 2'b00};
			if (r >= t) begin
				rem_n[k] = r - t;
				q_n[k]   = {q_s[k][dsr_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[k] = r;
				q_n[k]   = {q_s[k][dsr_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= !empty;
			for (int k = 0; k < N; k++) v_s[k+1] <= v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[0] <= head.kind;
			sgn_s[0]  <= head.sgn;
			rexp_s[0] <= head.rexp;
			mant_s[0] <= head.mant;
			q_s[0]    <= '0;
			rem_s[0]  <= '0;
			for (int k = 0; k < N; k++) begin
				kind_s[k+1] <= kind_s[k];
				sgn_s[k+1]  <= sgn_s[k];
				rexp_s[k+1] <= rexp_s[k];
				mant_s[k+1] <= mant_n[k];
				q_s[k+1]    <= q_n[k];
				rem_s[k+1]  <= rem_n[k];
			end
		end
	end

	always_comb begin
		logic rnd;
		rnd = (rem_s[N] > {3'b000, q_s[N]});
		unique case (kind_s[N])
			dsr_pkg::KIND_NORM: root_bits = {1'b0, rexp_s[N], 52'd0}
				+ {12'd0, q_s[N][dsr_pkg::FRAC_W-1:0]} + {63'd0, rnd};
			dsr_pkg::KIND_QNAN: root_bits = dsr_pkg::QNAN_BITS;
			dsr_pkg::KIND_INF:  root_bits = dsr_pkg::INF_BITS;
			dsr_pkg::KIND_ZERO: root_bits = {sgn_s[N], 63'd0};
			default:            root_bits = dsr_pkg::QNAN_BITS;
		endcase
	end

	assign root_valid = v_s[N];

endmodule

`default_nettype wire

// ===== rtl/core/double_square_root_core.sv =====
// ----------------------------------------------------------------------------
// double_square_root_core
// Binary64 square root, round to nearest; one operand per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage: present raw binary64 bits on operand_bits with operand_valid; the
// item is taken when operand_ready is also high. The root appears on
// root_bits with root_valid and leaves when root_ready is high.
// From operand acceptance to root_valid an item passes two front stages,
// the item queue and the 53 root-bit stages of the root pipeline.
// Throughput is one item per cycle while root_ready stays high; the 53-stage
// bit-recurrence pipeline computes one root bit per stage.
// Zeros and +inf pass through; NaN and negative operands give the canonical
// quiet NaN; subnormals are normalized in the front end.
// While a root waits on root_ready, the root pipeline holds; the front end
// keeps accepting into the queue until it fills, then drops operand_ready.
// Reset clears all valid bits and the queue; no item is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_square_root_core_macros.svh"

module double_square_root_core #(
	parameter int QUEUE_DEPTH = dsr_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         operand_valid,
	output logic              operand_ready,
	input  wire logic [63:0]  operand_bits,
	output logic              root_valid,
	input  wire logic         root_ready,
	output logic [63:0]       root_bits
);

	logic           q_full;
	logic           q_empty;
	logic           push;
	logic           pop;
	dsr_pkg::item_t push_item;
	dsr_pkg::item_t head;

	dsr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_ready (operand_ready),
		.operand_bits  (operand_bits),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	dsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	dsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (q_empty),
		.pop        (pop),
		.root_valid (root_valid),
		.root_ready (root_ready),
		.root_bits  (root_bits)
	);

	`DSR_ASSERT_NEVER(a_no_push_full, push && q_full, "push into full queue")
	`DSR_ASSERT_NEVER(a_no_pop_empty, pop && q_empty, "pop from empty queue")
	`DSR_ASSERT_IMP(a_stall_on_full, !operand_ready, q_full, "front stalled without full queue")

endmodule

`default_nettype wire

// ===== sim/double_square_root_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_square_root_checker
// Watches both channels of the binary64 square root core, computes the
// correctly rounded root of every accepted operand and compares it in order
// with every accepted root.
// ----------------------------------------------------------------------------
`default_nettype none

module double_square_root_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        operand_valid,
	input  wire logic        operand_ready,
	input  wire logic [63:0] operand_bits,
	input  wire logic        root_valid,
	input  wire logic        root_ready,
	input  wire logic [63:0] root_bits,
	output int               fail_count,
	output int               pending_roots
);

	logic [63:0] root_queue[$];

	function automatic logic [63:0] sqrt_bits(input logic [63:0] x);
		logic [63:0] mant;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] trial;
		logic [63:0] pair;
		logic [63:0] res;
		int          ex;
		int          shift;
		if (x[62:0] == 63'd0 || x == dsr_pkg::INF_BITS)
			return x;
		if (x[63] || x[62:52] == 11'h7ff)
			return dsr_pkg::QNAN_BITS;
		if (x[62:52] == 11'd0) begin
			mant = {12'd0, x[51:0]};
			shift = 0;
			while (!mant[52]) begin
				mant = mant << 1;
				shift++;
			end
			ex = -1022 - shift;
		end else begin
			mant = {11'd0, 1'b1, x[51:0]};
			ex = int'(x[62:52]) - 1023;
		end
		if (ex[0]) begin
			mant = mant << 1;
			ex = ex - 1;
		end
		q = 0;
		rem = 0;
		for (int i = 0; i < 53; i++) begin
			pair = (i < 27) ? ((mant >> (52 - 2 * i)) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (q << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				q = (q << 1) | 64'd1;
			end else begin
				q = q << 1;
			end
		end
		res = (64'(ex / 2 + 1023) << 52) + (q - 64'h0010_0000_0000_0000);
		if (rem > q)
			res = res + 64'd1;
		return res;
	endfunction

	assign pending_roots = root_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			root_queue.delete();
		end else begin
			if (operand_valid && operand_ready)
				root_queue.push_back(sqrt_bits(operand_bits));
			if (root_valid && root_ready) begin
				if (root_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected root %h", root_bits);
					fail_count <= fail_count + 1;
				end else begin
					want = root_queue.pop_front();
					if (want !== root_bits) begin
						if (fail_count < 10)
							$display("root mismatch: expected %h actual %h", want, root_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random binary64 operands into the square root core
// with bursty input and stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        operand_valid = 1'b0;
	logic        operand_ready;
	logic [63:0] operand_bits = 64'd0;
	logic        root_valid;
	logic        root_ready = 1'b0;
	logic [63:0] root_bits;
	int          fail_count;
	int          pending_roots;
	logic [63:0] directed_ops[$];

	always #2 clk = ~clk;

	double_square_root_core dut (.*);

	double_square_root_checker checker_i (.*);

	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0: v[62:52] = 11'd0;
			1: v[62:52] = 11'h7ff;
			2: v[62:52] = 11'($urandom_range(1, 3));
			3: v[62:52] = 11'($urandom_range(2044, 2046));
			4: v[51:0] = v[51:0] >> $urandom_range(51);
			default: v[63] = ($urandom_range(7) == 0);
		endcase
		return v;
	endfunction

	task automatic send_operand(input logic [63:0] v);
		operand_valid <= 1'b1;
		operand_bits <= v;
		@(posedge clk);
		while (!operand_ready)
			@(posedge clk);
	endtask

	task automatic idle_gap();
		operand_valid <= 1'b0;
		repeat ($urandom_range(1, 6))
			@(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		case ($urandom_range(3))
			0: root_ready <= 1'b1;
			1: root_ready <= ($urandom_range(3) != 0);
			2: root_ready <= ($urandom_range(1) == 0);
			default: root_ready <= ($urandom_range(5) == 0);
		endcase
	end

	initial begin
		int burst;
		directed_ops = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
			64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0001,
			64'hffff_ffff_ffff_ffff, 64'hbff0_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff, 64'h0008_0000_0000_0000,
			64'h0010_0000_0000_0000, 64'h7fef_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h4010_0000_0000_0000, 64'h3fef_ffff_ffff_ffff,
			64'h3ff0_0000_0000_0001, 64'h4022_0000_0000_0000, 64'h5555_5555_5555_5555,
			64'h2aaa_aaaa_aaaa_aaaa};
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_ops[i])
			send_operand(directed_ops[i]);
		// drain fully once
		operand_valid <= 1'b0;
		@(posedge clk);
		while (pending_roots != 0)
			@(posedge clk);
		for (int n = 0; n < 950; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < 950; k++, n++)
				send_operand(random_operand());
			if ($urandom_range(2) != 0)
				idle_gap();
		end
		operand_valid <= 1'b0;
		@(posedge clk);
		while (pending_roots != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (fail_count == 0)
			$display("double_square_root_core test passed");
		else
			$display("double_square_root_core test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("double_square_root_core test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dsr_pkg.sv
rtl/core/dsr_front.sv
rtl/core/dsr_queue.sv
rtl/core/dsr_back.sv
rtl/core/double_square_root_core.sv
sim/double_square_root_checker.sv
sim/tb.sv
